// ----- design/gbs_pkg.sv -----
// shared types and constants for greedy box suppression
`default_nettype none
package gbs_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int DESC_CNT_W = 7;
  localparam logic [15:0] THR_RESET = 16'd32768;

  // one stored box, left edge in the low bits
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // descriptor of one loaded set, front to back
  typedef struct packed {
    logic [DESC_CNT_W-1:0] count;
    logic                  ovf;
  } set_desc_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN,
    B_SCAN_END,
    B_MARK,
    B_TEST,
    B_DRAIN,
    B_DECIDE,
    B_EMIT_RD,
    B_EMIT_LOAD,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ----- design/gbs_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/gbs_desc_fifo.sv -----
// two entry queue of set descriptors between front and back
`default_nettype none
module gbs_desc_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire gbs_pkg::set_desc_t     wr_desc,
  output logic                        full_o,
  input  wire logic                   rd_en,
  output gbs_pkg::set_desc_t          rd_desc,
  output logic                        empty_o
);

  gbs_pkg::set_desc_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign rd_desc = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !full_o) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (rd_en && !empty_o) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((wr_en && !full_o) && !(rd_en && !empty_o)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(wr_en && !full_o) && (rd_en && !empty_o)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (wr_en && !full_o) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule
`default_nettype wire

// ----- design/gbs_front.sv -----
// front end: takes box items, stores them and closes a set on the final item
`default_nettype none
module gbs_front #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire gbs_pkg::box_t                  in_box,
  input  wire logic                           in_final,
  output logic                                ram_wr_en,
  output logic [$clog2(MAX_BOXES)-1:0]        ram_wr_addr,
  output gbs_pkg::box_t                       ram_wr_data,
  output logic                                desc_wr_en,
  output gbs_pkg::set_desc_t                  desc_wr,
  input  wire logic                           desc_full,
  input  wire logic                           set_done
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             busy_r, busy_nxt;
  logic             accept;
  logic             has_room;

  assign full     = busy_r || desc_full;
  assign accept   = push && !full;
  assign has_room = (count_r < CNT_W'(MAX_BOXES));

  // store the box while there is room
  assign ram_wr_en   = accept && has_room;
  assign ram_wr_addr = count_r[IDX_W-1:0];
  assign ram_wr_data = in_box;

  // count, overflow and set close
  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    busy_nxt   = busy_r;
    desc_wr_en = 1'b0;
    if (accept) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    desc_wr.count = gbs_pkg::DESC_CNT_W'(count_nxt);
    desc_wr.ovf   = ovf_nxt;
    if (accept && in_final) begin
      desc_wr_en = 1'b1;
      count_nxt  = '0;
      ovf_nxt    = 1'b0;
      busy_nxt   = 1'b1;
    end
    if (set_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/gbs_overlap.sv -----
// pipelined overlap test: inter * 65536 > threshold * union, four stages
`default_nettype none
module gbs_overlap (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld,
  input  wire gbs_pkg::box_t     kept_box,
  input  wire gbs_pkg::box_t     cand_box,
  input  wire logic [15:0]       thr,
  output logic                   res_vld,
  output logic                   res_hit,
  output logic                   busy
);

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;

  logic signed [16:0] pl, pt, pr, pb, ql, qt, qr, qb;
  logic signed [16:0] min_r, max_l, min_b, max_t, w_raw, h_raw;
  logic        [15:0] w_nxt, h_nxt;
  logic signed [16:0] dxp_nxt, dyp_nxt, dxc_nxt, dyc_nxt;

  logic        [15:0] w_r, h_r;
  logic signed [16:0] dxp_r, dyp_r, dxc_r, dyc_r;
  logic        [31:0] inter_r;
  logic signed [33:0] ap_r, ac_r;
  logic        [31:0] inter3_r;
  logic signed [35:0] uni_r;
  logic               hit_r;
  logic signed [53:0] lhs, rhs;

  // stage 1: clamped intersection sides and box sides
  always_comb begin
    pl = {kept_box.left[15], kept_box.left};
    pt = {kept_box.top[15], kept_box.top};
    pr = {kept_box.right[15], kept_box.right};
    pb = {kept_box.bottom[15], kept_box.bottom};
    ql = {cand_box.left[15], cand_box.left};
    qt = {cand_box.top[15], cand_box.top};
    qr = {cand_box.right[15], cand_box.right};
    qb = {cand_box.bottom[15], cand_box.bottom};
    min_r = (pr < qr) ? pr : qr;
    max_l = (pl > ql) ? pl : ql;
    min_b = (pb < qb) ? pb : qb;
    max_t = (pt > qt) ? pt : qt;
    w_raw = min_r - max_l;
    h_raw = min_b - max_t;
    w_nxt = w_raw[16] ? 16'd0 : w_raw[15:0];
    h_nxt = h_raw[16] ? 16'd0 : h_raw[15:0];
    dxp_nxt = pr - pl;
    dyp_nxt = pb - pt;
    dxc_nxt = qr - ql;
    dyc_nxt = qb - qt;
  end

  // stage 4 compare
  assign lhs = $signed({6'd0, inter3_r, 16'd0});
  assign rhs = 54'($signed({1'b0, thr}) * uni_r);

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    h_r   <= h_nxt;
    dxp_r <= dxp_nxt;
    dyp_r <= dyp_nxt;
    dxc_r <= dxc_nxt;
    dyc_r <= dyc_nxt;
    // stage 2: products
    inter_r <= w_r * h_r;
    ap_r    <= dxp_r * dyp_r;
    ac_r    <= dxc_r * dyc_r;
    // stage 3: union
    inter3_r <= inter_r;
    uni_r    <= 36'(ap_r) + 36'(ac_r) - $signed({4'd0, inter_r});
    // stage 4: threshold test
    hit_r <= (lhs > rhs);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  assign res_vld = s4_vld_r;
  assign res_hit = hit_r;
  assign busy    = s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r;

endmodule
`default_nettype wire

// ----- design/gbs_back.sv -----
// back end: ranks boxes by repeated max scan, tests each against kept boxes, emits
`default_nettype none
module gbs_back #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [15:0]                  cfg_wr_data,
  input  wire logic                         desc_empty,
  input  wire gbs_pkg::set_desc_t           desc_rd,
  output logic                              desc_rd_en,
  output logic                              box_rd_en,
  output logic [$clog2(MAX_BOXES)-1:0]      box_rd_addr,
  input  wire gbs_pkg::box_t                box_rd_data,
  output logic                              set_done,
  output gbs_pkg::box_t                     out_box,
  output logic                              out_eos,
  output logic                              out_ovf,
  output logic                              empty,
  input  wire logic                         pop
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  gbs_pkg::back_state_t state_r, state_nxt;

  logic [15:0]          thr_r;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0] ranked_r, ranked_nxt;
  logic [CNT_W-1:0]     ranked_cnt_r, ranked_cnt_nxt;
  logic [CNT_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 best_found_r, best_found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  gbs_pkg::box_t        cand_r, cand_nxt;
  logic [CNT_W-1:0]     kept_cnt_r, kept_cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 kq_vld_r, kq_vld_nxt;
  logic                 hit_r, hit_nxt;
  logic                 out_vld_r, out_vld_nxt;
  gbs_pkg::box_t        out_box_r, out_box_nxt;
  logic                 out_eos_r, out_eos_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 kept_wr_en;
  logic                 kept_rd_en;
  gbs_pkg::box_t        kept_rd_data;
  logic                 ov_vld, ov_hit, ov_busy, ov_res_vld;
  logic                 scan_last, test_last, emit_last, slot_free, better;

  assign scan_last = (CNT_W'(scan_addr_r + CNT_W'(1)) == n_r);
  assign test_last = (CNT_W'(idx_r + CNT_W'(1)) == kept_cnt_r);
  assign emit_last = test_last;
  assign slot_free = !out_vld_r || pop;
  assign better    = rd_vld_r && !ranked_r[rd_idx_r] &&
                     (!best_found_r || (box_rd_data.score > cand_r.score));

  // kept box store
  gbs_ram #(
    .WIDTH (gbs_pkg::BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_kept_ram (
    .clk     (clk),
    .wr_en   (kept_wr_en),
    .wr_addr (kept_cnt_r[IDX_W-1:0]),
    .wr_data (cand_r),
    .rd_en   (kept_rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (kept_rd_data)
  );

  // overlap unit
  assign ov_vld = kq_vld_r;

  gbs_overlap u_overlap (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld      (ov_vld),
    .kept_box (kept_rd_data),
    .cand_box (cand_r),
    .thr      (thr_r),
    .res_vld  (ov_res_vld),
    .res_hit  (ov_hit),
    .busy     (ov_busy)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbs_pkg::B_IDLE: begin
        if (!desc_empty) begin
          state_nxt = gbs_pkg::B_SCAN;
        end
      end
      gbs_pkg::B_SCAN: begin
        if (scan_last) begin
          state_nxt = gbs_pkg::B_SCAN_END;
        end
      end
      gbs_pkg::B_SCAN_END: begin
        state_nxt = gbs_pkg::B_MARK;
      end
      gbs_pkg::B_MARK: begin
        state_nxt = (kept_cnt_r == '0) ? gbs_pkg::B_DECIDE : gbs_pkg::B_TEST;
      end
      gbs_pkg::B_TEST: begin
        if (test_last) begin
          state_nxt = gbs_pkg::B_DRAIN;
        end
      end
      gbs_pkg::B_DRAIN: begin
        if (!kq_vld_r && !ov_busy) begin
          state_nxt = gbs_pkg::B_DECIDE;
        end
      end
      gbs_pkg::B_DECIDE: begin
        state_nxt = (ranked_cnt_r == n_r) ? gbs_pkg::B_EMIT_RD : gbs_pkg::B_SCAN;
      end
      gbs_pkg::B_EMIT_RD: begin
        state_nxt = gbs_pkg::B_EMIT_LOAD;
      end
      gbs_pkg::B_EMIT_LOAD: begin
        if (slot_free) begin
          state_nxt = emit_last ? gbs_pkg::B_DONE : gbs_pkg::B_EMIT_RD;
        end
      end
      gbs_pkg::B_DONE: begin
        state_nxt = gbs_pkg::B_IDLE;
      end
      default: begin
        state_nxt = gbs_pkg::B_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt          = n_r;
    ovf_nxt        = ovf_r;
    ranked_nxt     = ranked_r;
    ranked_cnt_nxt = ranked_cnt_r;
    scan_addr_nxt  = scan_addr_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    cand_nxt       = cand_r;
    kept_cnt_nxt   = kept_cnt_r;
    idx_nxt        = idx_r;
    kq_vld_nxt     = 1'b0;
    hit_nxt        = hit_r;
    out_vld_nxt    = out_vld_r && !pop;
    out_box_nxt    = out_box_r;
    out_eos_nxt    = out_eos_r;
    out_ovf_nxt    = out_ovf_r;
    desc_rd_en     = 1'b0;
    box_rd_en      = 1'b0;
    box_rd_addr    = scan_addr_r[IDX_W-1:0];
    kept_wr_en     = 1'b0;
    kept_rd_en     = 1'b0;
    set_done       = 1'b0;

    // best candidate so far, earliest wins ties
    if (better) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = rd_idx_r;
      cand_nxt       = box_rd_data;
    end
    // collect overlap results
    if (ov_res_vld && ov_hit) begin
      hit_nxt = 1'b1;
    end

    case (state_r)
      gbs_pkg::B_IDLE: begin
        if (!desc_empty) begin
          desc_rd_en     = 1'b1;
          n_nxt          = CNT_W'(desc_rd.count);
          ovf_nxt        = desc_rd.ovf;
          ranked_nxt     = '0;
          ranked_cnt_nxt = '0;
          kept_cnt_nxt   = '0;
          scan_addr_nxt  = '0;
          best_found_nxt = 1'b0;
        end
      end
      gbs_pkg::B_SCAN: begin
        box_rd_en     = 1'b1;
        rd_vld_nxt    = 1'b1;
        rd_idx_nxt    = scan_addr_r[IDX_W-1:0];
        scan_addr_nxt = CNT_W'(scan_addr_r + CNT_W'(1));
      end
      gbs_pkg::B_MARK: begin
        ranked_nxt[best_idx_r] = 1'b1;
        ranked_cnt_nxt         = CNT_W'(ranked_cnt_r + CNT_W'(1));
        idx_nxt                = '0;
        hit_nxt                = 1'b0;
      end
      gbs_pkg::B_TEST: begin
        kept_rd_en = 1'b1;
        kq_vld_nxt = 1'b1;
        idx_nxt    = CNT_W'(idx_r + CNT_W'(1));
      end
      gbs_pkg::B_DECIDE: begin
        if (!hit_r) begin
          kept_wr_en   = 1'b1;
          kept_cnt_nxt = CNT_W'(kept_cnt_r + CNT_W'(1));
        end
        scan_addr_nxt  = '0;
        best_found_nxt = 1'b0;
        idx_nxt        = '0;
      end
      gbs_pkg::B_EMIT_RD: begin
        kept_rd_en = 1'b1;
      end
      gbs_pkg::B_EMIT_LOAD: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
          out_box_nxt = kept_rd_data;
          out_eos_nxt = emit_last;
          out_ovf_nxt = ovf_r;
          idx_nxt     = CNT_W'(idx_r + CNT_W'(1));
        end
      end
      gbs_pkg::B_DONE: begin
        set_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gbs_pkg::B_IDLE;
      thr_r     <= gbs_pkg::THR_RESET;
      rd_vld_r  <= 1'b0;
      kq_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ranked_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_vld_nxt;
      kq_vld_r  <= kq_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ranked_r  <= ranked_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    ovf_r        <= ovf_nxt;
    ranked_cnt_r <= ranked_cnt_nxt;
    scan_addr_r  <= scan_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    cand_r       <= cand_nxt;
    kept_cnt_r   <= kept_cnt_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    out_box_r    <= out_box_nxt;
    out_eos_r    <= out_eos_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign empty   = !out_vld_r;
  assign out_box = out_box_r;
  assign out_eos = out_eos_r;
  assign out_ovf = out_ovf_r;

endmodule
`default_nettype wire

// ----- design/greedy_box_suppression_top.sv -----
// top level of greedy box suppression: front, set queue, box store and back
// Items are taken while full is low; a non-final item gives no result.
// After the final item a set of N boxes is reduced by a score scan per ranked box
// plus one overlap test per kept box through a single four-stage overlap unit,
// then each result is read from the kept store and loaded into the output register.
// Input stalls (full) from the final item until the last result is in the output register.
// Synchronous active-low reset empties the set and output; threshold returns to 32768.
`default_nettype none
module greedy_box_suppression_top #(
  parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_box_left,
  input  wire logic [15:0] in_box_top,
  input  wire logic [15:0] in_box_right,
  input  wire logic [15:0] in_box_bottom,
  input  wire logic [15:0] in_score,
  input  wire logic        in_final_box,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_kept_left,
  output logic [15:0]      out_kept_top,
  output logic [15:0]      out_kept_right,
  output logic [15:0]      out_kept_bottom,
  output logic [15:0]      out_kept_score,
  output logic             out_end_of_set,
  output logic             out_overflowed,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_BOXES);

  gbs_pkg::box_t      in_box, box_wr_data, box_rd_data, out_box;
  logic               box_wr_en, box_rd_en;
  logic [IDX_W-1:0]   box_wr_addr, box_rd_addr;
  gbs_pkg::set_desc_t desc_wr, desc_rd;
  logic               desc_wr_en, desc_rd_en, desc_full, desc_empty;
  logic               set_done;

  assign in_box.left   = in_box_left;
  assign in_box.top    = in_box_top;
  assign in_box.right  = in_box_right;
  assign in_box.bottom = in_box_bottom;
  assign in_box.score  = in_score;

  gbs_front #(
    .MAX_BOXES (MAX_BOXES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_box      (in_box),
    .in_final    (in_final_box),
    .ram_wr_en   (box_wr_en),
    .ram_wr_addr (box_wr_addr),
    .ram_wr_data (box_wr_data),
    .desc_wr_en  (desc_wr_en),
    .desc_wr     (desc_wr),
    .desc_full   (desc_full),
    .set_done    (set_done)
  );

  // box store shared by both ends
  gbs_ram #(
    .WIDTH (gbs_pkg::BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk     (clk),
    .wr_en   (box_wr_en),
    .wr_addr (box_wr_addr),
    .wr_data (box_wr_data),
    .rd_en   (box_rd_en),
    .rd_addr (box_rd_addr),
    .rd_data (box_rd_data)
  );

  gbs_desc_fifo u_desc_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (desc_wr_en),
    .wr_desc (desc_wr),
    .full_o  (desc_full),
    .rd_en   (desc_rd_en),
    .rd_desc (desc_rd),
    .empty_o (desc_empty)
  );

  gbs_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .desc_empty  (desc_empty),
    .desc_rd     (desc_rd),
    .desc_rd_en  (desc_rd_en),
    .box_rd_en   (box_rd_en),
    .box_rd_addr (box_rd_addr),
    .box_rd_data (box_rd_data),
    .set_done    (set_done),
    .out_box     (out_box),
    .out_eos     (out_end_of_set),
    .out_ovf     (out_overflowed),
    .empty       (empty),
    .pop         (pop)
  );

  assign out_kept_left   = out_box.left;
  assign out_kept_top    = out_box.top;
  assign out_kept_right  = out_box.right;
  assign out_kept_bottom = out_box.bottom;
  assign out_kept_score  = out_box.score;

endmodule
`default_nettype wire

// ----- design/gbs_checker.sv -----
// port-level checks for greedy box suppression, bound to the top level
`default_nettype none
module gbs_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        push,
  input wire logic        full,
  input wire logic        in_final_box,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] out_kept_left,
  input wire logic [15:0] out_kept_score,
  input wire logic        out_end_of_set
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kept_left) && $stable(out_kept_score) &&
                          $stable(out_end_of_set)))
    else $error("waiting item changed before pop");

  // reset leaves no result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // a closed set blocks further input
  a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_final_box) |=> full)
    else $error("input taken while a set is being reduced");

  // reset leaves the input open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input blocked after reset");

endmodule

bind greedy_box_suppression_top gbs_port_checks u_gbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .in_final_box   (in_final_box),
  .empty          (empty),
  .pop            (pop),
  .out_kept_left  (out_kept_left),
  .out_kept_score (out_kept_score),
  .out_end_of_set (out_end_of_set)
);
`default_nettype wire
